// ===== hdl/spiking_cpg_gait_network_assert.svh =====
// Assertion macros for the spiking gait network
`ifndef SPIKING_CPG_GAIT_NETWORK_ASSERT_SVH
`define SPIKING_CPG_GAIT_NETWORK_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SCPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scpg assertion failed");
`define SCPG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scpg implication failed");
`else
`define SCPG_ASSERT(lbl, prop)
`define SCPG_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== hdl/scpg_pkg.sv =====
// Constants and types of the spiking gait network
package scpg_pkg;

  localparam int N_NEURON  = 4;
  localparam int N_GAIT    = 5;
  localparam int N_SRC     = N_GAIT + N_NEURON;
  localparam int W_DEPTH   = N_NEURON * N_SRC;
  localparam int W_AW      = $clog2(W_DEPTH);
  localparam int WA_W      = $clog2(W_DEPTH + 1);
  localparam int NEURON_W  = (N_NEURON > 1) ? $clog2(N_NEURON) : 1;
  localparam int SRC_W     = $clog2(N_SRC);
  localparam int GAIT_W    = $clog2(N_GAIT + 1);
  localparam int GIDX_W    = (N_GAIT > 1) ? $clog2(N_GAIT) : 1;
  localparam int STEP_LAST = N_SRC + 1;
  localparam int STEP_W    = $clog2(STEP_LAST + 1);

  localparam int WEIGHT_W  = 16;
  localparam int V_W       = 20;
  localparam int WSUM_W    = V_W;
  localparam int DECAY_W   = 16;
  localparam int THR_W     = 18;
  localparam int CFG_W     = 18;
  localparam int IDX_W     = 6;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd59578;
  localparam logic [THR_W-1:0]   THR_RESET   = 18'd4096;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_GAIT = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic {
    CFG_DECAY = 1'b0,
    CFG_THR   = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

endpackage

// ===== hdl/spiking_cpg_gait_network.sv =====
// Four-neuron leaky integrate-and-fire gait network with weight and potential RAMs
//
//  channel  | dir | bits          | contents
//  s_axis   | in  | tdata 32, 2   | request: index, weight, gait; tuser op
//  m_axis   | out | tdata 16      | status: spikes, active, restart, phase, gait
//  cfg      | in  | idx 1, data18 | decay reciprocal, fire threshold
//
// Load, gait and idle ops write the output register directly.
// A tick steps through every neuron in turn: one weight RAM read per
// source and neuron, plus the potential read and the scale/write-back steps.
// Inputs are held off while a tick runs or while a result waits unaccepted.
// Reset: potentials read as zero until written; weights are undefined until loaded.

`include "spiking_cpg_gait_network_assert.svh"

module spiking_cpg_gait_network (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] weight_index, [21:6] weight_value, [24:22] gait, [31:25] zero
  input  logic [scpg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] neuron_spikes, [7:4] legs_active, [11:8] leg_restart,
  // [12] phase, [15:13] gait_latched
  output logic [scpg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [scpg_pkg::CFG_W-1:0]        cfg_data_i
);
  import scpg_pkg::*;

  state_e                     state_q;
  logic                       m_valid_q;
  logic [OUT_DATA_W-1:0]      m_data_q;
  logic [DECAY_W-1:0]         decay_q;
  logic [THR_W-1:0]           thr_q;
  logic [N_NEURON-1:0]        spikes_q;
  logic [N_GAIT-1:0]          pending_q;
  logic [GAIT_W-1:0]          latched_q;
  logic                       phase_q;
  logic [N_NEURON-1:0]        hist0_q, hist1_q;
  logic [N_NEURON-1:0]        vvalid_q;
  logic [N_NEURON-1:0]        fired_q, fired_d;
  logic [NEURON_W-1:0]        n_q;
  logic [STEP_W-1:0]          step_q;
  logic [WA_W-1:0]            wa_q;
  logic [N_SRC-1:0]           src_q;

  logic signed [WEIGHT_W-1:0] wmem [W_DEPTH];
  logic signed [WEIGHT_W-1:0] w_rd_q;
  logic signed [V_W-1:0]      vmem [N_NEURON];
  logic signed [V_W-1:0]      v_rd_q;
  logic signed [36:0]         prod_q;
  logic signed [36:0]         rnd;
  logic signed [V_W-1:0]      scaled_q;
  logic signed [WSUM_W-1:0]   wsum_q;
  logic signed [V_W-1:0]      v_eff;
  logic signed [V_W:0]        vsum;
  logic signed [V_W-1:0]      vsat;
  logic signed [V_W-1:0]      vnew;
  logic                       fire;

  logic                       in_acc;
  op_e                        op;
  logic [IDX_W-1:0]           in_idx;
  logic [WEIGHT_W-1:0]        in_w;
  logic [2:0]                 in_gait;
  logic                       gait_ok;
  logic [GAIT_W-1:0]          gait_hi;
  logic                       w_rd_en;
  logic                       last_step;
  logic                       tick_done;
  logic [N_NEURON-1:0]        hist0_d, hist1_d, active_d;

  assign op       = op_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[5:0];
  assign in_w     = s_axis_tdata[21:6];
  assign in_gait  = s_axis_tdata[24:22];

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign gait_ok = (in_gait >= 3'd1) && (32'(in_gait) <= N_GAIT) &&
                   (GAIT_W'(in_gait) != latched_q);

  always_comb begin
    gait_hi = latched_q;
    for (int s = 0; s < N_GAIT; s++) begin
      if (pending_q[s]) gait_hi = GAIT_W'(s + 1);
    end
  end

  assign w_rd_en   = (state_q == S_RUN) && (32'(step_q) < N_SRC);
  assign last_step = (state_q == S_RUN) && (32'(step_q) == STEP_LAST);
  assign tick_done = last_step && (32'(n_q) == N_NEURON - 1);

  assign v_eff = vvalid_q[n_q] ? v_rd_q : '0;
  assign rnd   = prod_q + 37'sd32768;
  assign vsum  = {scaled_q[V_W-1], scaled_q} + {wsum_q[WSUM_W-1], wsum_q};

  always_comb begin
    if (vsum[V_W] != vsum[V_W-1]) begin
      vsat = vsum[V_W] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
    end else begin
      vsat = vsum[V_W-1:0];
    end
    fire = vsat > $signed({{(V_W-THR_W){1'b0}}, thr_q});
    vnew = fire ? '0 : vsat;
    fired_d = fired_q;
    if (fire) fired_d[n_q] = 1'b1;
    hist0_d = hist0_q;
    hist1_d = hist1_q;
    if (phase_q) hist1_d = fired_d;
    else hist0_d = fired_d;
    active_d = hist0_d ^ hist1_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op == OP_LOAD && 32'(in_idx) < W_DEPTH) begin
      wmem[in_idx[W_AW-1:0]] <= in_w;
    end
    if (w_rd_en) begin
      w_rd_q <= wmem[wa_q[W_AW-1:0]];
    end
    if (state_q == S_RUN && step_q == '0) begin
      v_rd_q <= vmem[n_q];
    end
    if (last_step) begin
      vmem[n_q] <= vnew;
    end
    if (state_q == S_RUN && step_q == STEP_W'(1)) begin
      prod_q <= 37'(v_eff) * 37'($signed({1'b0, decay_q}));
    end
    if (state_q == S_RUN && step_q == STEP_W'(2)) begin
      scaled_q <= rnd[35:16];
    end
    if (state_q == S_RUN) begin
      if (step_q == '0) begin
        wsum_q <= '0;
      end else if (32'(step_q) <= N_SRC && src_q[SRC_W'(step_q - STEP_W'(1))]) begin
        wsum_q <= wsum_q + WSUM_W'(w_rd_q);
      end
    end
    if (in_acc && op != OP_TICK) begin
      m_data_q <= {latched_q, phase_q, 4'(0), 4'(hist0_q ^ hist1_q), 4'(spikes_q)};
    end else if (tick_done) begin
      m_data_q <= {latched_q, phase_q, 4'(fired_d & active_d), 4'(active_d), 4'(fired_d)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      decay_q   <= DECAY_RESET;
      thr_q     <= THR_RESET;
      spikes_q  <= '0;
      pending_q <= '0;
      latched_q <= '0;
      phase_q   <= 1'b1;
      hist0_q   <= '0;
      hist1_q   <= '0;
      vvalid_q  <= '0;
      fired_q   <= '0;
      n_q       <= '0;
      step_q    <= '0;
      wa_q      <= '0;
      src_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_DECAY: decay_q <= cfg_data_i[DECAY_W-1:0];
          CFG_THR:   thr_q   <= cfg_data_i[THR_W-1:0];
          default:   ;
        endcase
      end
      if (m_valid_q && m_axis_tready && !(in_acc && op != OP_TICK)) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_LOAD: m_valid_q <= 1'b1;
              OP_GAIT: begin
                m_valid_q <= 1'b1;
                if (gait_ok) pending_q[GIDX_W'(in_gait - 3'd1)] <= 1'b1;
              end
              OP_TICK: begin
                state_q   <= S_RUN;
                phase_q   <= ~phase_q;
                pending_q <= '0;
                fired_q   <= '0;
                n_q       <= '0;
                step_q    <= '0;
                wa_q      <= '0;
                if (pending_q != '0) begin
                  latched_q <= gait_hi;
                  vvalid_q  <= '0;
                  src_q     <= {{N_NEURON{1'b0}}, pending_q};
                end else begin
                  src_q     <= {spikes_q, pending_q};
                end
              end
              default: m_valid_q <= 1'b1;
            endcase
          end
        end
        S_RUN: begin
          if (w_rd_en) wa_q <= wa_q + WA_W'(1);
          if (last_step) begin
            fired_q       <= fired_d;
            vvalid_q[n_q] <= 1'b1;
            step_q        <= '0;
            n_q           <= n_q + NEURON_W'(1);
            if (tick_done) begin
              state_q   <= S_IDLE;
              spikes_q  <= fired_d;
              hist0_q   <= hist0_d;
              hist1_q   <= hist1_d;
              m_valid_q <= 1'b1;
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SCPG_ASSERT_IMPL(a_run_blocks_input, state_q == S_RUN, !s_axis_tready)
  `SCPG_ASSERT_IMPL(a_tick_starts_run, in_acc && op == OP_TICK, ##1 state_q == S_RUN)
  `SCPG_ASSERT_IMPL(a_step_in_range, state_q == S_RUN, 32'(step_q) <= STEP_LAST)
  `SCPG_ASSERT_IMPL(a_done_reads_all, tick_done, 32'(wa_q) == W_DEPTH)

endmodule

// ===== verif/spiking_cpg_gait_network_test.sv =====
// Self-checking testbench for the spiking gait network: weights, gaits, ticks and register phases
module spiking_cpg_gait_network_test;
  import scpg_pkg::*;

  localparam int  STALL_LIMIT = 3000;
  localparam int  PHASES      = 8;
  localparam int  PER_PHASE   = 180;
  localparam int  DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [IN_DATA_W-IDX_W-WEIGHT_W-GAIT_W-1:0] pad;
    logic [GAIT_W-1:0]   gait;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    index;
  } request_t;

  typedef struct packed {
    logic [GAIT_W-1:0]   gait;
    logic                phase;
    logic [N_NEURON-1:0] restart;
    logic [N_NEURON-1:0] active;
    logic [N_NEURON-1:0] spikes;
  } status_t;

  class gait_net_scoreboard;
    logic signed [WEIGHT_W-1:0] weights [W_DEPTH];
    logic signed [V_W-1:0]      potential [N_NEURON];
    logic [N_NEURON-1:0]        spikes;
    logic [N_GAIT-1:0]          pending_gaits;
    logic [GAIT_W-1:0]          latched;
    logic                       phase;
    logic [N_NEURON-1:0]        history [2];
    logic [DECAY_W-1:0]         decay_recip;
    logic [THR_W-1:0]           threshold;
    status_t                    expected_status [$];
    int                         mismatches;
    int                         checked;
    int                         spiking;
    int                         restarts;

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (potential[i]) potential[i] = '0;
      spikes        = '0;
      pending_gaits = '0;
      latched       = '0;
      phase         = 1'b1;
      history[0]    = '0;
      history[1]    = '0;
      decay_recip   = DECAY_RESET;
      threshold     = THR_RESET;
      mismatches    = 0;
      checked       = 0;
      spiking       = 0;
      restarts      = 0;
    endfunction

    function void set_register(cfg_e which, logic [CFG_W-1:0] value);
      case (which)
        CFG_DECAY: decay_recip = value[DECAY_W-1:0];
        CFG_THR:   threshold = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void advance_tick();
      longint v_hi, v_lo, v, dr, acc, thr, round_half;
      logic [N_NEURON-1:0] fired;
      logic on;
      v_hi       = (longint'(1) << (V_W - 1)) - 1;
      v_lo       = -(longint'(1) << (V_W - 1));
      round_half = longint'(1) << (DECAY_W - 1);
      thr        = longint'(threshold);
      dr         = longint'(decay_recip);
      fired      = '0;
      phase      = ~phase;
      if (pending_gaits != '0) begin
        for (int s = 0; s < N_GAIT; s++)
          if (pending_gaits[s]) latched = GAIT_W'(s + 1);
        spikes = '0;
        foreach (potential[i]) potential[i] = '0;
      end
      for (int n = 0; n < N_NEURON; n++) begin
        v   = longint'(potential[n]);
        acc = (v * dr + round_half) >>> DECAY_W;
        for (int s = 0; s < N_SRC; s++) begin
          on = (s < N_GAIT) ? pending_gaits[s] : spikes[s - N_GAIT];
          if (on) acc = acc + longint'(weights[n * N_SRC + s]);
        end
        if (acc > v_hi) acc = v_hi;
        if (acc < v_lo) acc = v_lo;
        if (acc > thr) begin
          fired[n] = 1'b1;
          acc = 0;
        end
        potential[n] = acc[V_W-1:0];
      end
      spikes         = fired;
      pending_gaits  = '0;
      history[phase] = fired;
    endfunction

    function void note_request(op_e op, logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] w,
                               logic [GAIT_W-1:0] g);
      status_t st;
      st.restart = '0;
      case (op)
        OP_LOAD: if (idx < W_DEPTH) weights[idx] = w;
        OP_GAIT: if (g >= 1 && g <= N_GAIT && g != latched) pending_gaits[g - 1] = 1'b1;
        OP_TICK: begin
          advance_tick();
          st.restart = spikes & (history[0] ^ history[1]);
        end
        default: ;
      endcase
      st.spikes = spikes;
      st.active = history[0] ^ history[1];
      st.phase  = phase;
      st.gait   = latched;
      expected_status.push_back(st);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("status #%0d %s = %0d, expected %0d", checked, name, got,
                                  want));
    endtask

    task check_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("status 0x%04h with no request outstanding", got));
      end else begin
        want = expected_status.pop_front();
        compare_field("neuron_spikes", int'(got.spikes), int'(want.spikes));
        compare_field("legs_active", int'(got.active), int'(want.active));
        compare_field("leg_restart", int'(got.restart), int'(want.restart));
        compare_field("phase", int'(got.phase), int'(want.phase));
        compare_field("gait_latched", int'(got.gait), int'(want.gait));
        if (want.spikes != '0) spiking++;
        if (want.restart != '0) restarts++;
      end
      checked++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;

  gait_net_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int requests_sent;
  int ticks_sent;
  int stall_cycles;

  spiking_cpg_gait_network dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check on handshake, then pick next stall
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no handshake on either side
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(op_e op, logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] w,
                              logic [GAIT_W-1:0] g);
    request_t req;
    req = '{pad: '0, gait: g, weight: w, index: idx};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, idx, w, g);
    requests_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_registers(logic [DECAY_W-1:0] decay, logic [THR_W-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DECAY;
    cfg_data_i  <= CFG_W'(decay);
    @(posedge clk_i);
    sb.set_register(CFG_DECAY, CFG_W'(decay));
    cfg_index_i <= CFG_THR;
    cfg_data_i  <= CFG_W'(thr);
    @(posedge clk_i);
    sb.set_register(CFG_THR, CFG_W'(thr));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    if ($urandom_range(3) == 0) return WEIGHT_W'($urandom);
    return WEIGHT_W'(int'($urandom_range(0, 16383)) - 4096);
  endfunction

  task automatic run_random(int count);
    int done, sel, bursts;
    logic [IDX_W-1:0] idx;
    logic [GAIT_W-1:0] g;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(W_DEPTH, 63))
                                       : IDX_W'($urandom_range(0, W_DEPTH - 1));
        send_request(OP_LOAD, idx, pick_weight(), GAIT_W'($urandom));
        if (idx < W_DEPTH) done++;
      end else if (sel < 13) begin
        send_request(OP_NONE, IDX_W'($urandom), WEIGHT_W'($urandom), GAIT_W'($urandom));
      end else if (sel < 18) begin
        g = GAIT_W'($urandom);
        send_request(OP_GAIT, IDX_W'($urandom), WEIGHT_W'($urandom), g);
        if (g >= 1 && g <= N_GAIT) done++;
      end else begin
        bursts = $urandom_range(0, 2);
        repeat (bursts) begin
          send_request(OP_GAIT, IDX_W'($urandom), WEIGHT_W'($urandom),
                       GAIT_W'($urandom_range(1, N_GAIT)));
          done++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_request(OP_TICK, IDX_W'($urandom), WEIGHT_W'($urandom), GAIT_W'($urandom));
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [DECAY_W-1:0] decay_plan [5];
    logic [THR_W-1:0]   thr_plan [5];
    int idle_plan [4];
    int stall_plan [4];
    logic [DECAY_W-1:0] decay;
    logic [THR_W-1:0]   thr;
    decay_plan = '{DECAY_RESET, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
    thr_plan   = '{THR_RESET, 18'h00000, 18'h3FFFF, 18'h00000, 18'h3FFFF};
    idle_plan  = '{0, 70, 0, 28};
    stall_plan = '{0, 0, 70, 28};
    requests_sent  = 0;
    ticks_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_NONE;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_DECAY;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every weight is written before the first tick
    for (int i = 0; i < W_DEPTH; i++) begin
      if (i % N_SRC < N_GAIT)
        send_request(OP_LOAD, IDX_W'(i), WEIGHT_W'($urandom_range(2048, 12288)), '0);
      else
        send_request(OP_LOAD, IDX_W'(i), WEIGHT_W'(int'($urandom_range(0, 12287)) - 6144),
                     '0);
    end

    // directed corner cases
    send_request(OP_NONE, '0, '0, '0);
    send_request(OP_GAIT, '0, '0, 3'd0);
    send_request(OP_GAIT, '0, '0, 3'd6);
    send_request(OP_GAIT, '1, '1, 3'd7);
    send_request(OP_LOAD, IDX_W'(W_DEPTH), 16'h7FFF, '0);
    send_request(OP_LOAD, 6'd63, 16'h8000, '0);
    send_request(OP_LOAD, 6'd0, 16'h7FFF, '0);
    send_request(OP_LOAD, 6'd1, 16'h8000, '0);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_GAIT, '0, '0, 3'd3);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_GAIT, '0, '0, 3'd3);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_GAIT, '0, '0, 3'd1);
    send_request(OP_GAIT, '0, '0, 3'd5);
    send_request(OP_GAIT, '0, '0, 3'd2);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_GAIT, '0, '0, 3'd4);
    send_request(OP_NONE, '1, '1, '1);
    send_request(OP_TICK, '1, '1, '1);
    send_request(OP_LOAD, IDX_W'(W_DEPTH - 1), pick_weight(), '0);
    send_request(OP_TICK, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      decay = (p < 5) ? decay_plan[p] : DECAY_W'($urandom_range(32768, 65535));
      thr   = (p < 5) ? thr_plan[p] : THR_W'($urandom_range(0, 16384));
      write_registers(decay, thr);
      send_idle_pct  = idle_plan[p % 4];
      recv_stall_pct = stall_plan[p % 4];
      run_random(PER_PHASE);
    end

    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.expected_status.size() != 0)
      sb.report_mismatch($sformatf("%0d statuses never arrived", sb.expected_status.size()));

    $display("Sent %0d requests (%0d ticks) over %0d register and handshake phases",
             requests_sent, ticks_sent, PHASES);
    $display("Checked %0d statuses: %0d with spikes, %0d with leg restarts, %0d mismatches",
             sb.checked, sb.spiking, sb.restarts, sb.mismatches);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/scpg_pkg.sv
hdl/spiking_cpg_gait_network.sv
verif/spiking_cpg_gait_network_test.sv
